// ===== rtl/sieve_prime_count_macros.svh =====
// Assertion helpers used by the sieve prime count top level.
`ifndef SIEVE_PRIME_COUNT_MACROS_SVH
`define SIEVE_PRIME_COUNT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SPC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sieve_prime_count: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define SPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sieve_prime_count: next-cycle check failed");

`endif

// ===== rtl/spc_pkg.sv =====
package spc_pkg;

    // Width of the limit and count fields.
    localparam int unsigned DATA_W = 16;

    // Largest limit that a 16-bit field can carry.
    localparam int unsigned FIELD_MAX = 65535;

    // Upper bound on the count for any 16-bit limit.
    localparam logic [DATA_W-1:0] COUNT_BOUND = 16'd6542;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_TEST  = 6'b001000,
        ST_MARK  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

// ===== rtl/spc_map.sv =====
module spc_map #(
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned AW    = 16
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);

    logic mem [DEPTH];
    logic rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/spc_walk.sv =====
module spc_walk #(
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned AW    = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // item intake
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [AW-1:0]              in_lim,
    // result hand-off
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [spc_pkg::DATA_W-1:0] res_count,
    // map port
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic                       wr_data,
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr,
    input  logic                       rd_data
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] TWO       = AW'(2);

    spc_pkg::state_t state_reg, state_next;
    logic [AW-1:0]              a_reg, a_next;
    logic [2*AW-1:0]            sq_reg, sq_next;
    logic [AW:0]                b_reg, b_next;
    logic [AW-1:0]              lim_reg, lim_next;
    logic [spc_pkg::DATA_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]              clr_reg, clr_next;

    logic [AW-1:0]   a_inc;
    logic [2*AW-1:0] sq_inc;
    logic [AW:0]     b_inc;
    logic            sq_fits;

    // Next number and its square, kept without a multiplier
    assign a_inc   = a_reg + AW'(1);
    assign sq_inc  = sq_reg + {{(AW-1){1'b0}}, a_reg, 1'b1};
    assign b_inc   = b_reg + {1'b0, a_reg};
    assign sq_fits = (sq_reg <= {{AW{1'b0}}, lim_reg});

    assign in_ready  = (state_reg == spc_pkg::ST_IDLE);
    assign res_valid = (state_reg == spc_pkg::ST_DONE);
    assign res_count = cnt_reg;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        sq_next    = sq_reg;
        b_next     = b_reg;
        lim_next   = lim_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        wr_en      = 1'b0;
        wr_addr    = a_reg;
        wr_data    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = a_reg;

        unique case (state_reg)
            spc_pkg::ST_CLEAR: begin
                // sweep the whole map once after reset
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == LAST_ADDR) begin
                    state_next = spc_pkg::ST_IDLE;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            spc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    lim_next = in_lim;
                    cnt_next = '0;
                    a_next   = TWO;
                    sq_next  = (2*AW)'(4);
                    if (in_lim < TWO) begin
                        state_next = spc_pkg::ST_DONE;
                    end else begin
                        state_next = spc_pkg::ST_READ;
                    end
                end
            end
            spc_pkg::ST_READ: begin
                rd_en      = 1'b1;
                state_next = spc_pkg::ST_TEST;
            end
            spc_pkg::ST_TEST: begin
                // clear the bit behind the walk so the next transaction finds it zero
                wr_en   = 1'b1;
                wr_addr = a_reg;
                wr_data = 1'b0;
                // prefetch the next number
                rd_en   = (a_reg != lim_reg);
                rd_addr = a_inc;
                if (!rd_data) begin
                    cnt_next = cnt_reg + spc_pkg::DATA_W'(1);
                end
                if (!rd_data && sq_fits) begin
                    b_next     = {1'b0, sq_reg[AW-1:0]};
                    state_next = spc_pkg::ST_MARK;
                end else if (a_reg == lim_reg) begin
                    state_next = spc_pkg::ST_DONE;
                end else begin
                    a_next  = a_inc;
                    sq_next = sq_inc;
                end
            end
            spc_pkg::ST_MARK: begin
                // mark one multiple per cycle
                wr_en   = 1'b1;
                wr_addr = b_reg[AW-1:0];
                wr_data = 1'b1;
                if (b_inc > {1'b0, lim_reg}) begin
                    a_next     = a_inc;
                    sq_next    = sq_inc;
                    state_next = spc_pkg::ST_READ;
                end else begin
                    b_next = b_inc;
                end
            end
            spc_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = spc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spc_pkg::ST_CLEAR;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spc_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Walk registers
    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        sq_reg  <= sq_next;
        b_reg   <= b_next;
        lim_reg <= lim_next;
        cnt_reg <= cnt_next;
    end

endmodule

// ===== rtl/sieve_prime_count.sv =====
// Prime counter built on a sieve of Eratosthenes over a one-bit-per-number map.
// Input channel s_*: one transaction carries a limit N in s_tdata. A limit above
// MAX_LIMIT is taken as MAX_LIMIT. Output channel m_*: one transaction per input
// carries the number of primes p with 2 <= p <= N; limits below 2 give zero.
// After reset the block sweeps the map once, one entry per cycle, over all
// min(MAX_LIMIT, 65535) + 1 entries (65536 by default); s_tready stays low then.
// Each item walks over 2..N, testing each number and, for each prime p with
// p*p <= N, marking its multiples from p*p up to N. The map's single read port
// and single write port allow one number tested or one multiple marked per
// cycle. Each tested bit is cleared as the walk passes it, so no per-item sweep
// is needed. One item is worked on at a time; the next is accepted while the
// previous result waits in the output register. If the receiver stalls, a
// finished result waits inside the block and no further item is accepted.
`include "sieve_prime_count_macros.svh"

module sieve_prime_count #(
    parameter int unsigned MAX_LIMIT = 65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] limit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] prime_count
);

    localparam int unsigned CAP   = (MAX_LIMIT < spc_pkg::FIELD_MAX) ? MAX_LIMIT
                                                                     : spc_pkg::FIELD_MAX;
    localparam int unsigned DEPTH = CAP + 1;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [AW-1:0]              lim_sat;
    logic                       res_valid;
    logic                       res_ready;
    logic [spc_pkg::DATA_W-1:0] res_count;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic                       wr_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       rd_data;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [spc_pkg::DATA_W-1:0] m_tdata_reg;

    // Saturate the limit to the map's last address
    assign lim_sat = (s_tdata > spc_pkg::DATA_W'(CAP)) ? AW'(CAP) : s_tdata[AW-1:0];

    spc_walk #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_lim    (lim_sat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_count (res_count),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    spc_map #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: load when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= res_count;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `SPC_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SPC_ASSERT_SAME(a_map_port, aclk, aresetn, wr_en && rd_en, wr_addr != rd_addr)
    `SPC_ASSERT_SAME(a_count_bound, aclk, aresetn, m_tvalid, m_tdata <= spc_pkg::COUNT_BOUND)

endmodule

// ===== sim/tb.sv =====
module tb;

    localparam int unsigned MAX_LIMIT   = 65535;
    localparam int unsigned CYCLE_LIMIT = 8000000;
    localparam int unsigned TAIL_ITEMS  = 15;
    localparam int unsigned RAND_ITEMS  = 76;
    localparam int unsigned HOLD_AT     = 40;
    localparam int unsigned HOLD_LEN    = 30000;
    localparam int unsigned DRAIN_WAIT  = 64;

    typedef struct packed {
        logic [spc_pkg::DATA_W-1:0] limit;
        logic [spc_pkg::DATA_W-1:0] count;
    } count_exp_t;

    logic                       aclk     = 1'b0;
    logic                       aresetn  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [spc_pkg::DATA_W-1:0] s_tdata  = '0;   // [15:0] limit
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [spc_pkg::DATA_W-1:0] m_tdata;         // [15:0] prime_count

    logic [spc_pkg::DATA_W-1:0] limit_queue[$];
    count_exp_t                 count_queue[$];
    bit                         composite_map[0:MAX_LIMIT];

    int unsigned total_items   = 0;
    int unsigned items_sent    = 0;
    int unsigned counts_seen   = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned src_gap       = 0;
    int unsigned sink_gap      = 0;
    int unsigned hold_left     = 0;
    logic [spc_pkg::DATA_W-1:0] largest_limit = '0;
    bit          hold_active   = 1'b0;
    bit          hold_done     = 1'b0;

    sieve_prime_count #(
        .MAX_LIMIT (MAX_LIMIT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Sieve over a freshly cleared map and count the primes up to the limit
    function automatic logic [spc_pkg::DATA_W-1:0] count_primes(
        input logic [spc_pkg::DATA_W-1:0] limit);
        longint unsigned lim;
        longint unsigned a;
        longint unsigned b;
        longint unsigned cnt;
        lim = 64'(limit);
        cnt = 0;
        if (lim > MAX_LIMIT)
            lim = MAX_LIMIT;
        for (longint unsigned i = 0; i <= lim; i++)
            composite_map[i] = 1'b0;
        for (a = 2; a <= lim; a++) begin
            if (!composite_map[a]) begin
                cnt++;
                for (b = a * a; b <= lim; b += a)
                    composite_map[b] = 1'b1;
            end
        end
        return cnt[spc_pkg::DATA_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Cycle counter and timeout guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d counts still awaited",
                     cycle_count, count_queue.size());
            $display("tb failed");
            $finish;
        end
    end

    // Driver: feed limits from the pending queue, with random idle bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                count_queue.push_back('{limit: s_tdata, count: count_primes(s_tdata)});
                if (s_tdata > largest_limit)
                    largest_limit <= s_tdata;
                items_sent <= items_sent + 1;
            end
            // pick the next transaction once the slot is free
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (limit_queue.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (items_sent + TAIL_ITEMS < total_items &&
                             $urandom_range(0, 5) == 0) begin
                    src_gap  <= $urandom_range(0, 17);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= limit_queue.pop_front();
                end
            end
        end
    end

    // Long output stall, started once after a number of inputs went in
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_active <= 1'b0;
            hold_left   <= 0;
        end else if (hold_active) begin
            if (hold_left == 0) begin
                hold_active <= 1'b0;
                hold_done   <= 1'b1;
            end else begin
                hold_left <= hold_left - 1;
            end
        end else if (!hold_done && items_sent >= HOLD_AT) begin
            hold_active <= 1'b1;
            hold_left   <= HOLD_LEN - 1;
        end
    end

    // Monitor: check each count against the oldest expectation, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                counts_seen <= counts_seen + 1;
                if (count_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected count %0d", m_tdata));
                end else begin
                    count_exp_t exp_item;
                    exp_item = count_queue.pop_front();
                    if (m_tdata !== exp_item.count)
                        report_mismatch($sformatf("limit %0d: prime_count %0d, expected %0d",
                                                  exp_item.limit, m_tdata, exp_item.count));
                end
            end
            // hold ready low during the long stall and idle bursts
            if (hold_active) begin
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else if (counts_seen + TAIL_ITEMS < total_items &&
                         $urandom_range(0, 7) == 0) begin
                sink_gap <= $urandom_range(0, 17);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int unsigned pick;
        logic [spc_pkg::DATA_W-1:0] directed[$];
        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd8,
                     16'd9, 16'd10, 16'd11, 16'd13, 16'd25, 16'd49, 16'd97, 16'd100,
                     16'd121, 16'd255, 16'd256, 16'd1023, 16'd65535, 16'd4096, 16'd2};
        foreach (directed[i])
            limit_queue.push_back(directed[i]);
        // mostly small limits, a few medium ones
        for (int i = 0; i < RAND_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                limit_queue.push_back(spc_pkg::DATA_W'($urandom_range(0, 300)));
            else if (pick < 95)
                limit_queue.push_back(spc_pkg::DATA_W'($urandom_range(0, 1500)));
            else
                limit_queue.push_back(spc_pkg::DATA_W'($urandom_range(1500, 4000)));
        end
        total_items = limit_queue.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for every limit to go in and every count to come back
        while (items_sent < total_items || count_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("summary: %0d limits from 0 up to %0d sent, %0d prime counts checked",
                 items_sent, largest_limit, counts_seen);
        $display("summary: one output stall of %0d cycles with input backpressure, %0d mismatches",
                 HOLD_LEN, mismatches);
        if (mismatches == 0 && count_queue.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
